// ----- sv/hrbf_pkg.sv -----
package hrbf_pkg;

   localparam int MaxCentersDefault = 256;
   localparam int FracBitsDefault   = 16;

   localparam int CountW   = 9;
   localparam int CoordW   = 32;
   localparam int FieldW   = 48;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 32;

   // Square root of a sum of three squared 33-bit differences.
   localparam int RootW = 34;
   localparam int RadW  = 2 * RootW;

   localparam logic [63:0] AccLim = 64'h3FFF_FFFF_FFFF_FFFF;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_CENTER_COUNT = 3'd0,
      CSR_POLY_AX      = 3'd1,
      CSR_POLY_AY      = 3'd2,
      CSR_POLY_AZ      = 3'd3,
      CSR_POLY_B       = 3'd4
   } csr_index_type;

   typedef struct packed {
      op_type                    op;
      logic [7:0]                slot;
      logic signed [CoordW-1:0]  coord_x;
      logic signed [CoordW-1:0]  coord_y;
      logic signed [CoordW-1:0]  coord_z;
      logic signed [CoordW-1:0]  weight_value;
      logic signed [CoordW-1:0]  weight_grad_x;
      logic signed [CoordW-1:0]  weight_grad_y;
      logic signed [CoordW-1:0]  weight_grad_z;
   } req_type;

   typedef struct packed {
      logic signed [FieldW-1:0] field_value;
      logic                     saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [CoordW-1:0] center_x;
      logic signed [CoordW-1:0] center_y;
      logic signed [CoordW-1:0] center_z;
      logic signed [CoordW-1:0] alpha_weight;
      logic signed [CoordW-1:0] beta_weight_x;
      logic signed [CoordW-1:0] beta_weight_y;
      logic signed [CoordW-1:0] beta_weight_z;
   } center_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_DIFF,
      ST_SQ,
      ST_SQRT,
      ST_R3,
      ST_ALPHA,
      ST_G,
      ST_BETA,
      ST_POLY,
      ST_BIAS,
      ST_OUT
   } state_type;

endpackage

// ----- sv/hrbf_center_mem.sv -----
module hrbf_center_mem #(
   parameter int Depth = hrbf_pkg::MaxCentersDefault,
   parameter int AddrW = 8
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AddrW-1:0]           wr_addr,
   input  hrbf_pkg::center_entry_type wr_data,
   input  logic                       rd_en,
   input  logic [AddrW-1:0]           rd_addr,
   output hrbf_pkg::center_entry_type rd_data
);
   import hrbf_pkg::*;

   center_entry_type mem_ff [Depth];
   center_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/hrbf_mul64.sv -----
module hrbf_mul64 (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   op_a,
   input  logic [63:0]   op_b,
   output logic          done,
   output logic [127:0]  product
);
   import hrbf_pkg::*;

   // Four 32x32 partial products, one per cycle, each registered and then added into the product.
   logic         busy_ff;
   logic         done_ff;
   logic [2:0]   step_ff;
   logic [63:0]  a_ff;
   logic [63:0]  b_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   sh_ff;
   logic [127:0] prod_ff;

   logic [31:0]  a_part;
   logic [31:0]  b_part;
   logic [1:0]   sh_in;
   logic [63:0]  pp_in;
   logic [127:0] pp_wide;

   always_comb begin
      unique case (step_ff[1:0])
         2'd0: begin
            a_part = a_ff[31:0];
            b_part = b_ff[31:0];
            sh_in  = 2'd0;
         end
         2'd1: begin
            a_part = a_ff[31:0];
            b_part = b_ff[63:32];
            sh_in  = 2'd1;
         end
         2'd2: begin
            a_part = a_ff[63:32];
            b_part = b_ff[31:0];
            sh_in  = 2'd1;
         end
         default: begin
            a_part = a_ff[63:32];
            b_part = b_ff[63:32];
            sh_in  = 2'd2;
         end
      endcase
      pp_in   = {32'd0, a_part} * {32'd0, b_part};
      pp_wide = {64'd0, pp_ff} << {sh_ff, 5'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 3'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff    <= op_a;
         b_ff    <= op_b;
         prod_ff <= 128'd0;
      end else if (busy_ff) begin
         if (step_ff != 3'd4) begin
            pp_ff <= pp_in;
            sh_ff <= sh_in;
         end
         if (step_ff != 3'd0) begin
            prod_ff <= prod_ff + pp_wide;
         end
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// ----- sv/hrbf_isqrt.sv -----
module hrbf_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [hrbf_pkg::RadW-1:0]     radicand,
   output logic                          done,
   output logic [hrbf_pkg::RootW-1:0]    root
);
   import hrbf_pkg::*;

   localparam int CntW = $clog2(RootW + 1);

   // Restoring square root, one result bit per cycle.
   logic                busy_ff;
   logic                done_ff;
   logic [CntW-1:0]     cnt_ff;
   logic [RadW-1:0]     rad_ff;
   logic [RootW+1:0]    rem_ff;
   logic [RootW-1:0]    root_ff;

   logic [RootW+3:0]    rem_sh;
   logic [RootW+3:0]    trial;
   logic                take;
   logic [RootW+1:0]    rem_in;
   logic [RootW-1:0]    root_in;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[RadW-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      take    = rem_sh >= trial;
      rem_in  = take ? (RootW+2)'(rem_sh - trial) : (RootW+2)'(rem_sh);
      root_in = {root_ff[RootW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntW'(RootW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CntW'(1);
            if (cnt_ff == CntW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RadW-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- sv/hermite_rbf_field_evaluator.sv -----
// Loads are written to the centre memory when accepted and give no response. A
// query's response time grows with the number of active centres, and the next
// request is taken once the response is loaded into its register. The time is
// set by the 34-step square root and the 64x64 products (four partial products).
// One request is worked at a time; a finished response may wait in its register
// while the next request is taken. Synchronous active-high reset clears control
// and configuration; the centre memory is undefined until loaded.
module hermite_rbf_field_evaluator #(
   parameter int MAX_CENTERS = hrbf_pkg::MaxCentersDefault,
   parameter int FRAC_BITS   = hrbf_pkg::FracBitsDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  hrbf_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output hrbf_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [hrbf_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [hrbf_pkg::CsrDataW-1:0]   csr_wr_data
);
   import hrbf_pkg::*;

   localparam int AddrW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
   localparam int CntW  = $clog2(MAX_CENTERS + 1);

   localparam logic signed [64:0] Lim65  = 65'sh0_3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] OutMax = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] OutMin = -64'sh0000_8000_0000_0000;

   // Configuration registers.
   logic [CountW-1:0]        count_ff;
   logic signed [31:0]       poly_ff [3];
   logic signed [31:0]       bias_ff;

   // Sequencer and datapath registers.
   state_type                state_ff, state_in;
   logic                     issued_ff;
   logic [CntW-1:0]          idx_ff;
   logic [CntW-1:0]          n_ff;
   logic [1:0]               k_ff;
   logic signed [31:0]       p_ff [3];
   logic [32:0]              dmag_ff [3];
   logic                     dneg_ff [3];
   logic [RadW-1:0]          r2_ff;
   logic [RootW-1:0]         r_ff;
   logic [61:0]              r3_ff;
   logic [63:0]              g_ff;
   logic signed [63:0]       acc_ff;
   logic                     clip_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   // Handshake and unit control.
   logic                     req_accept;
   logic                     mem_wr_en;
   logic [AddrW-1:0]         mem_wr_addr;
   logic                     mem_rd_en;
   logic [31:0]              slot_wide;
   logic [31:0]              count_wide;
   logic [CntW-1:0]          n_eff;
   logic [CntW-1:0]          idx_next;
   logic                     last_center;
   center_entry_type         entry;
   center_entry_type         wr_entry;

   logic                     mul_start;
   logic [63:0]              mul_a;
   logic [63:0]              mul_b;
   logic                     mul_done;
   logic [127:0]             mul_product;
   logic                     sqrt_start;
   logic                     sqrt_done;
   logic [RootW-1:0]         sqrt_root;
   logic                     out_load;

   // Per-axis views of the current centre.
   logic signed [31:0]       c_sel [3];
   logic signed [31:0]       beta_sel [3];
   logic signed [32:0]       d_val [3];
   logic [31:0]              beta_mag;
   logic [33:0]              beta3;
   logic [31:0]              alpha_mag;
   logic [31:0]              coef_mag;
   logic [31:0]              pk_mag;

   // Scaled product, clipping and saturating accumulate.
   logic [127:0]             prod_sh;
   logic                     term_clip;
   logic [63:0]              term_mag;
   logic                     term_neg;
   logic signed [63:0]       term_val;
   logic signed [63:0]       add_val;
   logic signed [64:0]       acc_sum;
   logic signed [63:0]       acc_in;
   logic                     acc_clip;
   logic signed [FieldW-1:0] out_value;
   logic                     out_clip;

   assign req_accept  = req_valid && !req_stall;
   assign slot_wide   = 32'(req_data.slot);
   assign mem_wr_addr = slot_wide[AddrW-1:0];
   assign mem_wr_en   = req_accept && (req_data.op == OP_LOAD)
                        && (slot_wide < 32'(MAX_CENTERS));
   assign count_wide  = 32'(count_ff);
   assign n_eff       = (count_wide > 32'(MAX_CENTERS)) ? CntW'(MAX_CENTERS)
                                                        : CntW'(count_wide);
   assign idx_next    = idx_ff + CntW'(1);
   assign last_center = idx_next == n_ff;

   always_comb begin
      wr_entry.center_x      = req_data.coord_x;
      wr_entry.center_y      = req_data.coord_y;
      wr_entry.center_z      = req_data.coord_z;
      wr_entry.alpha_weight  = req_data.weight_value;
      wr_entry.beta_weight_x = req_data.weight_grad_x;
      wr_entry.beta_weight_y = req_data.weight_grad_y;
      wr_entry.beta_weight_z = req_data.weight_grad_z;
   end

   hrbf_center_mem #(
      .Depth (MAX_CENTERS),
      .AddrW (AddrW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (wr_entry),
      .rd_en   (mem_rd_en),
      .rd_addr (idx_ff[AddrW-1:0]),
      .rd_data (entry)
   );

   hrbf_mul64 u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   hrbf_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (r2_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // The entry read from memory stays in the read register for the whole
   // centre, so the per-axis selections below are taken from it directly.
   always_comb begin
      c_sel[0]    = entry.center_x;
      c_sel[1]    = entry.center_y;
      c_sel[2]    = entry.center_z;
      beta_sel[0] = entry.beta_weight_x;
      beta_sel[1] = entry.beta_weight_y;
      beta_sel[2] = entry.beta_weight_z;
      for (int i = 0; i < 3; i++) begin
         d_val[i] = {p_ff[i][31], p_ff[i]} - {c_sel[i][31], c_sel[i]};
      end
      beta_mag  = beta_sel[k_ff][31] ? 32'(-beta_sel[k_ff]) : 32'(beta_sel[k_ff]);
      beta3     = {2'b00, beta_mag} + {1'b0, beta_mag, 1'b0};
      alpha_mag = entry.alpha_weight[31] ? 32'(-entry.alpha_weight)
                                         : 32'(entry.alpha_weight);
      coef_mag  = poly_ff[k_ff][31] ? 32'(-poly_ff[k_ff]) : 32'(poly_ff[k_ff]);
      pk_mag    = p_ff[k_ff][31] ? 32'(-p_ff[k_ff]) : 32'(p_ff[k_ff]);
   end

   // The product of each term and of the r-cubed step is scaled back by the fraction bits and
   // clipped to the accumulator limit; the sign is then applied as the term requires.
   always_comb begin
      prod_sh   = mul_product >> FRAC_BITS;
      term_clip = |prod_sh[127:62];
      term_mag  = term_clip ? AccLim : {2'b00, prod_sh[61:0]};
      unique case (state_ff)
         ST_ALPHA: term_neg = entry.alpha_weight[31];
         ST_BETA:  term_neg = dneg_ff[k_ff] == beta_sel[k_ff][31];
         ST_POLY:  term_neg = poly_ff[k_ff][31] != p_ff[k_ff][31];
         default:  term_neg = 1'b0;
      endcase
      term_val = term_neg ? -$signed(term_mag) : $signed(term_mag);
      add_val  = (state_ff == ST_BIAS) ? 64'(bias_ff) : term_val;
      acc_sum  = $signed({acc_ff[63], acc_ff}) + $signed({add_val[63], add_val});
      if (acc_sum > Lim65) begin
         acc_in   = $signed(AccLim);
         acc_clip = 1'b1;
      end else if (acc_sum < -Lim65) begin
         acc_in   = -$signed(AccLim);
         acc_clip = 1'b1;
      end else begin
         acc_in   = acc_sum[63:0];
         acc_clip = 1'b0;
      end
      if (acc_ff > OutMax) begin
         out_value = OutMax[FieldW-1:0];
         out_clip  = 1'b1;
      end else if (acc_ff < OutMin) begin
         out_value = OutMin[FieldW-1:0];
         out_clip  = 1'b1;
      end else begin
         out_value = acc_ff[FieldW-1:0];
         out_clip  = 1'b0;
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_data.op == OP_QUERY)) begin
               state_in = (n_eff == '0) ? ST_POLY : ST_READ;
            end
         end
         ST_READ: state_in = ST_DIFF;
         ST_DIFF: state_in = ST_SQ;
         ST_SQ: begin
            if (mul_done && (k_ff == 2'd2)) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               state_in = ST_R3;
            end
         end
         ST_R3: begin
            if (mul_done) begin
               state_in = ST_ALPHA;
            end
         end
         ST_ALPHA: begin
            if (mul_done) begin
               state_in = ST_G;
            end
         end
         ST_G: begin
            if (mul_done) begin
               state_in = ST_BETA;
            end
         end
         ST_BETA: begin
            if (mul_done) begin
               if (k_ff != 2'd2) begin
                  state_in = ST_G;
               end else if (last_center) begin
                  state_in = ST_POLY;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_POLY: begin
            if (mul_done && (k_ff == 2'd2)) begin
               state_in = ST_BIAS;
            end
         end
         ST_BIAS: state_in = ST_OUT;
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: request stall, memory read, unit starts, operands and response load.
   always_comb begin
      req_stall  = state_ff != ST_IDLE;
      mem_rd_en  = state_ff == ST_READ;
      sqrt_start = (state_ff == ST_SQRT) && !issued_ff;
      out_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
      mul_a      = '0;
      mul_b      = '0;
      mul_start  = 1'b0;
      unique case (state_ff)
         ST_SQ: begin
            mul_start = !issued_ff;
            mul_a     = 64'(dmag_ff[k_ff]);
            mul_b     = 64'(dmag_ff[k_ff]);
         end
         ST_R3: begin
            mul_start = !issued_ff;
            mul_a     = 64'(r2_ff >> FRAC_BITS);
            mul_b     = 64'(r_ff);
         end
         ST_ALPHA: begin
            mul_start = !issued_ff;
            mul_a     = 64'(r3_ff);
            mul_b     = 64'(alpha_mag);
         end
         ST_G: begin
            mul_start = !issued_ff;
            mul_a     = 64'(r_ff);
            mul_b     = 64'(dmag_ff[k_ff]);
         end
         ST_BETA: begin
            mul_start = !issued_ff;
            mul_a     = g_ff;
            mul_b     = 64'(beta3);
         end
         ST_POLY: begin
            mul_start = !issued_ff;
            mul_a     = 64'(coef_mag);
            mul_b     = 64'(pk_mag);
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         poly_ff[0]   <= '0;
         poly_ff[1]   <= '0;
         poly_ff[2]   <= '0;
         bias_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (mul_start || sqrt_start) begin
            issued_ff <= 1'b1;
         end else if (mul_done || sqrt_done) begin
            issued_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_CENTER_COUNT: count_ff   <= csr_wr_data[CountW-1:0];
               CSR_POLY_AX:      poly_ff[0] <= csr_wr_data;
               CSR_POLY_AY:      poly_ff[1] <= csr_wr_data;
               CSR_POLY_AZ:      poly_ff[2] <= csr_wr_data;
               CSR_POLY_B:       bias_ff    <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers, advanced as each unit reports completion and in the idle, difference, bias and output states.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_data.op == OP_QUERY)) begin
               p_ff[0] <= req_data.coord_x;
               p_ff[1] <= req_data.coord_y;
               p_ff[2] <= req_data.coord_z;
               n_ff    <= n_eff;
               idx_ff  <= '0;
               k_ff    <= 2'd0;
               acc_ff  <= '0;
               clip_ff <= 1'b0;
            end
         end
         ST_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               dneg_ff[i] <= d_val[i][32];
               dmag_ff[i] <= d_val[i][32] ? 33'(-d_val[i]) : 33'(d_val[i]);
            end
            r2_ff <= '0;
            k_ff  <= 2'd0;
         end
         ST_SQ: begin
            if (mul_done) begin
               r2_ff <= r2_ff + RadW'(mul_product[65:0]);
               k_ff  <= (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               r_ff <= sqrt_root;
            end
         end
         ST_R3: begin
            if (mul_done) begin
               r3_ff <= term_mag[61:0];
               if (term_clip) begin
                  clip_ff <= 1'b1;
               end
            end
         end
         ST_ALPHA: begin
            if (mul_done) begin
               acc_ff  <= acc_in;
               clip_ff <= clip_ff | term_clip | acc_clip;
               k_ff    <= 2'd0;
            end
         end
         ST_G: begin
            if (mul_done) begin
               g_ff <= prod_sh[63:0];
            end
         end
         ST_BETA: begin
            if (mul_done) begin
               acc_ff  <= acc_in;
               clip_ff <= clip_ff | term_clip | acc_clip;
               if (k_ff == 2'd2) begin
                  k_ff   <= 2'd0;
                  idx_ff <= idx_next;
               end else begin
                  k_ff <= k_ff + 2'd1;
               end
            end
         end
         ST_POLY: begin
            if (mul_done) begin
               acc_ff  <= acc_in;
               clip_ff <= clip_ff | term_clip | acc_clip;
               k_ff    <= (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
            end
         end
         ST_BIAS: begin
            acc_ff  <= acc_in;
            clip_ff <= clip_ff | acc_clip;
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_data_ff.field_value <= out_value;
               rsp_data_ff.saturated   <= clip_ff | out_clip;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // The multiplier and the square root unit are never started together.
   assert property (@(posedge clock) disable iff (reset)
      !(mul_start && sqrt_start))
      else $error("multiplier and square root started in the same cycle");

   // No unit may still be running once the sequencer is back at rest.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !issued_ff)
      else $error("arithmetic unit busy while idle");

   // The difference state, which first uses the memory read data, always follows the read state.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIFF) |-> ($past(state_ff) == ST_READ))
      else $error("centre data used without a preceding read");

   // An accepted query always leaves the idle state.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.op == OP_QUERY)) |=> (state_ff != ST_IDLE))
      else $error("query accepted but not started");
`endif

endmodule
